@@ sv/audio_gain_peak_meter_assert.svh @@
`ifndef AUDIO_GAIN_PEAK_METER_ASSERT_SVH
`define AUDIO_GAIN_PEAK_METER_ASSERT_SVH

// Assertion helpers; expect clk and rst_n in the enclosing scope.

// Same-cycle implication.
`define AGPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AGPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/agpm_pkg.sv @@
package agpm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 17;
  localparam int OUT_W    = 32;
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  // control from the pipeline to the peak tracker
  typedef struct packed {
    logic upd;   // word moves into the result register
    logic ch;    // channel of that word
    logic last;  // word ends its packet
  } peak_ctl_t;

endpackage

@@ sv/audio_gain_peak_meter.sv @@
// Channel  Dir  Fields (lowest bit up)
// in_      in   tdata: sample_in[15:0]; tlast: last_of_packet
// out_     out  tdata: scaled_sample[31:0], peak_left[63:32], peak_right[95:64];
//               tuser: channel; tlast: peak_valid
// cfg_     in   wr_data: gain[16:0], written when wr_en is high
//
// Two registered stages: input register, then multiply/saturate/peak
// compare into the result register. One word per cycle sustained while out_tready
// stays high; out_tvalid rises once the word is loaded into the result register.
// in_tready holds high while the result register drains, so a stalled
// output only stops intake once both stages are full.
// rst_n is synchronous: gain back to 32, peaks cleared, channel to left.
module audio_gain_peak_meter (
  input  logic         clk,
  input  logic         rst_n,

  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,     // sample_in[15:0]
  input  logic         in_tlast,     // last_of_packet

  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,    // scaled_sample[31:0], peak_left[63:32],
                                     // peak_right[95:64]
  output logic         out_tuser,    // channel
  output logic         out_tlast,    // peak_valid

  input  logic         cfg_wr_en,
  input  logic [16:0]  cfg_wr_data   // gain[16:0]
);

  `include "audio_gain_peak_meter_assert.svh"

  // gain register
  logic [agpm_pkg::GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= agpm_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  // handshake
  logic in_acc, adv;
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  assign adv       = !out_valid_r || out_tready;   // result register free
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  // channel toggle, advanced at accept
  logic toggle_r, toggle_nxt;

  always_comb begin
    toggle_nxt = toggle_r;
    if (in_acc) begin
      toggle_nxt = in_tlast ? agpm_pkg::CH_LEFT : ~toggle_r;
    end
  end

  // input stage
  logic signed [agpm_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic                                 s1_last_r;
  logic                                 s1_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      toggle_r    <= agpm_pkg::CH_LEFT;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      toggle_r    <= toggle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_tdata;
      s1_last_r   <= in_tlast;
      s1_ch_r     <= toggle_r;
    end
  end

  // scale and peak
  logic [agpm_pkg::OUT_W-1:0] scaled, mag, pk_left, pk_right;
  agpm_pkg::peak_ctl_t        pk_ctl;

  agpm_scale u_scale (
    .sample (s1_sample_r),
    .gain   (gain_r),
    .scaled (scaled),
    .mag    (mag)
  );

  assign pk_ctl.upd  = s1_valid_r && adv;
  assign pk_ctl.ch   = s1_ch_r;
  assign pk_ctl.last = s1_last_r;

  agpm_peak u_peak (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pk_ctl),
    .mag        (mag),
    .peak_left  (pk_left),
    .peak_right (pk_right)
  );

  // result register
  logic [agpm_pkg::OUT_W-1:0] out_scaled_r, out_left_r, out_right_r;
  logic                       out_ch_r, out_last_r;

  always_ff @(posedge clk) begin
    if (pk_ctl.upd) begin
      out_scaled_r <= scaled;
      out_left_r   <= pk_left;
      out_right_r  <= pk_right;
      out_ch_r     <= s1_ch_r;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_right_r, out_left_r, out_scaled_r};
  assign out_tuser  = out_ch_r;
  assign out_tlast  = out_last_r;

  // checks
  `AGPM_ASSERT_NEXT(a_last_resets_ch, in_acc && in_tlast, toggle_r == agpm_pkg::CH_LEFT,
    "channel toggle not back to left after packet end")
  `AGPM_ASSERT_NOW(a_peaks_zero_midpkt, out_tvalid && !out_tlast, out_tdata[95:32] == 64'd0,
    "peaks nonzero on a word that does not end its packet")
  `AGPM_ASSERT_NEXT(a_s1_held, s1_valid_r && !adv, s1_valid_r,
    "input stage dropped a word while the result register was stalled")
  `AGPM_ASSERT_NOW(a_accept_room, in_acc, !s1_valid_r || !out_valid_r || out_tready,
    "word accepted with both stages full")

endmodule

@@ sv/agpm_scale.sv @@
module agpm_scale (
  input  logic signed [agpm_pkg::SAMPLE_W-1:0] sample,
  input  logic        [agpm_pkg::GAIN_W-1:0]   gain,
  output logic        [agpm_pkg::OUT_W-1:0]    scaled,
  output logic        [agpm_pkg::OUT_W-1:0]    mag
);

  logic signed [agpm_pkg::PROD_W-1:0] prod;
  logic                               fits;

  assign prod = sample * $signed({1'b0, gain});

  // in range when the top three bits agree
  assign fits = (prod[33:31] == 3'b000) || (prod[33:31] == 3'b111);

  always_comb begin
    if (fits) begin
      scaled = prod[31:0];
    end else if (prod[33]) begin
      scaled = agpm_pkg::SAT_NEG;
    end else begin
      scaled = agpm_pkg::SAT_POS;
    end
  end

  // -2^31 maps to 0x8000_0000, read unsigned
  assign mag = scaled[31] ? (~scaled + 32'd1) : scaled;

endmodule

@@ sv/agpm_peak.sv @@
module agpm_peak (
  input  logic                         clk,
  input  logic                         rst_n,
  input  agpm_pkg::peak_ctl_t          ctl,
  input  logic [agpm_pkg::OUT_W-1:0]   mag,
  output logic [agpm_pkg::OUT_W-1:0]   peak_left,
  output logic [agpm_pkg::OUT_W-1:0]   peak_right
);

  logic [agpm_pkg::OUT_W-1:0] left_r, right_r;
  logic [agpm_pkg::OUT_W-1:0] left_nxt, right_nxt;

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    if (ctl.ch == agpm_pkg::CH_LEFT) begin
      if (mag > left_r) left_nxt = mag;
    end else begin
      if (mag > right_r) right_nxt = mag;
    end
  end

  // peaks include the current word; zero unless it ends the packet
  assign peak_left  = ctl.last ? left_nxt  : '0;
  assign peak_right = ctl.last ? right_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (ctl.upd) begin
      if (ctl.last) begin
        left_r  <= '0;
        right_r <= '0;
      end else begin
        left_r  <= left_nxt;
        right_r <= right_nxt;
      end
    end
  end

endmodule

@@ verif/gain_meter_check.sv @@
// Watches the sample and result streams of audio_gain_peak_meter, predicts every result word
// and compares field by field.
module gain_meter_check
  import agpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [15:0]         in_tdata,
  input  logic                in_tlast,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [95:0]         out_tdata,
  input  logic                out_tuser,
  input  logic                out_tlast,
  input  logic                cfg_wr_en,
  input  logic [GAIN_W-1:0]   cfg_wr_data,
  output int                  bad_words,
  output int                  words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_W-1:0] scaled;
    logic             ch;
    logic             peak_valid;
    logic [OUT_W-1:0] peak_l;
    logic [OUT_W-1:0] peak_r;
  } meter_word_t;

  localparam longint PROD_MAX = 64'sd2147483647;
  localparam longint PROD_MIN = -64'sd2147483648;

  meter_word_t         meter_due[$];
  logic [GAIN_W-1:0]   gain_now;
  logic [OUT_W-1:0]    left_peak;
  logic [OUT_W-1:0]    right_peak;
  logic                next_ch;

  initial begin
    bad_words = 0;
    words_due = 0;
  end

  // sample * gain, clipped to the 32-bit signed range
  function automatic logic [OUT_W-1:0] scale_sample(input logic signed [SAMPLE_W-1:0] s,
                                                    input logic [GAIN_W-1:0] g);
    longint p;
    p = longint'(s) * longint'(g);
    if (p > PROD_MAX) return SAT_POS;
    if (p < PROD_MIN) return SAT_NEG;
    return p[OUT_W-1:0];
  endfunction

  // |v| as unsigned; 0x8000_0000 maps onto itself
  function automatic logic [OUT_W-1:0] magnitude(input logic [OUT_W-1:0] v);
    return v[OUT_W-1] ? -v : v;
  endfunction

  always @(posedge clk) begin
    meter_word_t       want;
    meter_word_t       got;
    logic [OUT_W-1:0]  mag;
    if (!rst_n) begin
      gain_now   = GAIN_RESET;
      left_peak  = '0;
      right_peak = '0;
      next_ch    = CH_LEFT;
      meter_due.delete();
    end else begin
      if (cfg_wr_en) gain_now = cfg_wr_data;

      if (out_tvalid && out_tready) begin
        got.scaled     = out_tdata[31:0];
        got.peak_l     = out_tdata[63:32];
        got.peak_r     = out_tdata[95:64];
        got.ch         = out_tuser;
        got.peak_valid = out_tlast;
        if (meter_due.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("%0t unexpected word: scaled %h ch %b pv %b L %h R %h", $realtime,
                     got.scaled, got.ch, got.peak_valid, got.peak_l, got.peak_r);
        end else begin
          want = meter_due.pop_front();
          if (got.scaled !== want.scaled || got.ch !== want.ch ||
              got.peak_valid !== want.peak_valid || got.peak_l !== want.peak_l ||
              got.peak_r !== want.peak_r) begin
            bad_words++;
            if (bad_words <= 10) begin
              $display("%0t mismatch: scaled %h/%h ch %b/%b pv %b/%b (exp/act)", $realtime,
                       want.scaled, got.scaled, want.ch, got.ch,
                       want.peak_valid, got.peak_valid);
              $display("  peak_left %h/%h peak_right %h/%h (exp/act)",
                       want.peak_l, got.peak_l, want.peak_r, got.peak_r);
            end
          end
        end
      end

      if (in_tvalid && in_tready) begin
        want.scaled = scale_sample(in_tdata, gain_now);
        want.ch     = next_ch;
        mag         = magnitude(want.scaled);
        if (next_ch == CH_LEFT) begin
          if (mag > left_peak) left_peak = mag;
        end else begin
          if (mag > right_peak) right_peak = mag;
        end
        want.peak_valid = in_tlast;
        want.peak_l     = in_tlast ? left_peak : '0;
        want.peak_r     = in_tlast ? right_peak : '0;
        meter_due.push_back(want);
        // packet end clears both peaks and restarts on left
        if (in_tlast) begin
          left_peak  = '0;
          right_peak = '0;
          next_ch    = CH_LEFT;
        end else begin
          next_ch = ~next_ch;
        end
      end
    end
    words_due = meter_due.size();
  end

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import agpm_pkg::*;

  // consecutive cycles without any word moving before the run is called dead;
  // the long receiver hold-off below is set by HOLD_CYCLES
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 12;
  localparam int PHASE_WORDS  = 155;
  localparam int HOLD_PHASE   = 4;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_tvalid    = 1'b0;
  logic               in_tready;
  logic [15:0]        in_tdata     = '0;
  logic               in_tlast     = 1'b0;
  logic               out_tvalid;
  logic               out_tready   = 1'b0;
  logic [95:0]        out_tdata;
  logic               out_tuser;
  logic               out_tlast;
  logic               cfg_wr_en    = 1'b0;
  logic [GAIN_W-1:0]  cfg_wr_data  = '0;

  int                 bad_words;
  int                 words_due;
  int                 quiet_cycles = 0;

  // traffic shaping knobs, flipped by the stimulus process
  bit                 tx_gaps_on   = 1'b1;
  bit                 rx_stalls_on = 1'b1;
  bit                 hold_req     = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  audio_gain_peak_meter DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  gain_meter_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .bad_words   (bad_words),
    .words_due   (words_due)
  );

  // Receiver: out_tready is assigned at falling edges and held through stalls. A requested
  // hold-off keeps ready low until the HOLD_CYCLES wait ends, so the two DUT stages fill and in_tready drops.
  always begin
    @(negedge clk);
    if (hold_req) begin
      out_tready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(negedge clk);
      hold_req = 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: any accepted word on either stream resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("[audio_gain_peak_meter] ERROR");
        $finish;
      end
    end
  end

  // Offer one sample word, optionally after a random gap, and hold it until taken.
  // tvalid stays high on return so back-to-back words need no re-raise.
  task automatic send_word(input logic [15:0] s, input logic last);
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Gain only changes with the block drained: drop tvalid, wait for every
  // predicted word to come back, then pulse the write enable for one cycle.
  task automatic set_gain(input logic [GAIN_W-1:0] g);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Biased toward full scale and near zero so peaks and sign edges get hit often.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int               sent;
    int               plen;
    logic [GAIN_W-1:0] g;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // reset gain (32): full-scale pair, then a one-word packet ending on left
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b1);
    send_word(16'hFFFF, 1'b1);

    // unity-at-2^16: -32768 * 65536 lands exactly on -2^31, peak must read 2^31
    set_gain(17'd65536);
    send_word(16'h8000, 1'b0);
    send_word(16'h7FFF, 1'b1);
    // three-word packet, last word on left; alternating bit patterns
    send_word(16'h5555, 1'b0);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h0000, 1'b1);

    // top gain: both signs clip, both channels carry the max peak
    set_gain(17'h1FFFF);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h7FFF, 1'b1);

    // gain zero: everything collapses to zero, peaks zero
    set_gain(17'd0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b1);

    // gain one: pass-through
    set_gain(17'd1);
    send_word(16'h0001, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'd12345, 1'b1);

    // --- random packets, one gain per phase ---
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 6))
        0:       g = 17'd65536;
        1:       g = 17'h1FFFF;
        2:       g = 17'($urandom_range(0, 255));
        3:       g = GAIN_RESET;
        4:       g = 17'($urandom_range(65537, 131071));
        default: g = 17'($urandom_range(0, 65536));
      endcase
      set_gain(g);

      // one phase starts with the receiver held off while words keep coming
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      // final phase runs at full rate on both sides
      if (ph == PHASES - 1) begin
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
      end else begin
        tx_gaps_on   = $urandom_range(0, 3) != 0;
        rx_stalls_on = $urandom_range(0, 3) != 0;
      end

      sent = 0;
      while (sent < PHASE_WORDS) begin
        // mostly stereo pairs, a random length from 1 to 15 now and then
        plen = $urandom_range(0, 4) == 0 ? $urandom_range(1, 15) : 2 * $urandom_range(1, 8);
        for (int i = 0; i < plen; i++) begin
          send_word(pick_sample(), i == plen - 1);
          sent++;
        end
      end
    end

    // drain: wait for every predicted word to come back, then idle before the verdict
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    if (bad_words == 0 && words_due == 0)
      $display("[audio_gain_peak_meter] OK");
    else
      $display("[audio_gain_peak_meter] ERROR");
    $finish;
  end

endmodule
